// ===== rtl/ebaf_pkg.sv =====
package ebaf_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int MAX_RADIUS_DEF = 3;
  localparam int TIME_BITS_DEF  = 32;

  // fixed field widths
  localparam int PIX_W      = 8;
  localparam int TS_W       = 32;
  localparam int WIN_W      = 32;
  localparam int RAD_REG_W  = 2;
  localparam int DIM_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // register reset values
  localparam logic [WIN_W-1:0]     TIME_WINDOW_RST  = WIN_W'(10000);
  localparam logic [RAD_REG_W-1:0] RADIUS_RST       = RAD_REG_W'(1);
  localparam logic [DIM_W-1:0]     FRAME_WIDTH_RST  = DIM_W'(256);
  localparam logic [DIM_W-1:0]     FRAME_HEIGHT_RST = DIM_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_WINDOW  = 2'd0,
    CFG_RADIUS       = 2'd1,
    CFG_FRAME_WIDTH  = 2'd2,
    CFG_FRAME_HEIGHT = 2'd3
  } cfg_reg_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input event
    logic rd;        // read one neighbor, advance position
    logic wr;        // write own pixel entry
    logic clr;       // clearing pass write
    logic out_load;  // move event into output register
  } ebaf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_frame;
    logic pos_last;
    logic pass;
    logic clr_last;
    logic out_free;
  } ebaf_sts_t;

endpackage

// ===== rtl/event_background_activity_filter.sv =====
// Events are processed one at a time: one timestamp-map read per cycle over the (2r+1)^2
//   neighborhood, r = min(radius, MAX_RADIUS), then one write of the own pixel, then the result.
//   The next event is taken only once the result, if any, has a place to go, so out_stall_i can
//   hold the flow. An event outside the frame is dropped without a scan.
// Reset: asynchronous, active low. A clearing pass over all MAX_WIDTH*MAX_HEIGHT entries (65536 by
//   default) then zeroes both maps; inputs stall meanwhile, config writes are taken.
module event_background_activity_filter
  import ebaf_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // event input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PIX_W-1:0]      pixel_x_i,
  input  logic [PIX_W-1:0]      pixel_y_i,
  input  logic                  polarity_i,
  input  logic [TS_W-1:0]       timestamp_i,
  // passed events
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIX_W-1:0]      out_x_o,
  output logic [PIX_W-1:0]      out_y_o,
  output logic                  out_polarity_o,
  output logic [TS_W-1:0]       out_timestamp_o
);

  // Configuration registers. Raw values are kept; saturation to the
  // MAX_* limits happens in the datapath.
  logic [WIN_W-1:0]     time_window_q;
  logic [RAD_REG_W-1:0] radius_q;
  logic [DIM_W-1:0]     frame_width_q;
  logic [DIM_W-1:0]     frame_height_q;

  ebaf_cmd_t cmd;
  ebaf_sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_window_q  <= TIME_WINDOW_RST;
      radius_q       <= RADIUS_RST;
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_TIME_WINDOW:  time_window_q  <= cfg_wdata_i[WIN_W-1:0];
        CFG_RADIUS:       radius_q       <= cfg_wdata_i[RAD_REG_W-1:0];
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i[DIM_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: clearing pass, then per event a scan of the square
  // neighborhood (one map read per cycle), own-pixel write, result.
  ebaf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Timestamp maps (valid bit packed with each entry), address generation,
  // support compare and the output register, which frees the sequencer to
  // take the next event while a result waits for transfer.
  ebaf_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .time_window_i   (time_window_q),
    .radius_i        (radius_q),
    .frame_width_i   (frame_width_q),
    .frame_height_i  (frame_height_q),
    .pixel_x_i       (pixel_x_i),
    .pixel_y_i       (pixel_y_i),
    .polarity_i      (polarity_i),
    .timestamp_i     (timestamp_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_x_o         (out_x_o),
    .out_y_o         (out_y_o),
    .out_polarity_o  (out_polarity_o),
    .out_timestamp_o (out_timestamp_o)
  );

endmodule

// ===== rtl/ebaf_ram.sv =====
module ebaf_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ebaf_ctrl.sv =====
module ebaf_ctrl
  import ebaf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ebaf_sts_t sts_i,
  output ebaf_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        if (!sts_i.in_frame) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.rd = 1'b1;
          if (sts_i.pos_last) begin
            state_d = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        cmd_o.wr = 1'b1;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        // finish once the result (if any) has a place to go
        if (!sts_i.pass || sts_i.out_free) begin
          cmd_o.out_load = sts_i.pass;
          in_stall_o     = 1'b0;
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            state_d    = ST_READ;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  a_wr_in_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr |-> sts_i.in_frame)
    else $error("own-pixel write for an out-of-frame event");

  a_wr_after_rd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr |-> $past(cmd_o.rd))
    else $error("own-pixel write not directly after last neighbor read");

  a_clr_alone : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clr |-> (!cmd_o.load && !cmd_o.rd && !cmd_o.wr))
    else $error("event activity during clearing pass");

endmodule

// ===== rtl/ebaf_dp.sv =====
module ebaf_dp
  import ebaf_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ebaf_cmd_t            cmd_i,
  output ebaf_sts_t            sts_o,
  input  logic [WIN_W-1:0]     time_window_i,
  input  logic [RAD_REG_W-1:0] radius_i,
  input  logic [DIM_W-1:0]     frame_width_i,
  input  logic [DIM_W-1:0]     frame_height_i,
  input  logic [PIX_W-1:0]     pixel_x_i,
  input  logic [PIX_W-1:0]     pixel_y_i,
  input  logic                 polarity_i,
  input  logic [TS_W-1:0]      timestamp_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PIX_W-1:0]     out_x_o,
  output logic [PIX_W-1:0]     out_y_o,
  output logic                 out_polarity_o,
  output logic [TS_W-1:0]      out_timestamp_o
);

  localparam int NPIX    = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = $clog2(NPIX);
  localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
  localparam int CNT_W   = $clog2(2 * MAX_RADIUS + 1);
  localparam int COORD_W = PIX_W + 2;
  localparam int CMP_W   = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;
  localparam int WORD_W  = TIME_BITS + 1;

  // event register
  logic [PIX_W-1:0] x_q, y_q;
  logic             pol_q;
  logic [TS_W-1:0]  ts_q;

  // neighborhood scan
  logic [CNT_W-1:0] cx_q, cy_q;
  logic             rd_pend_q;
  logic             pass_q;
  logic [ADDR_W-1:0] clr_addr_q;

  // output register
  logic             out_valid_q;
  logic [PIX_W-1:0] out_x_q, out_y_q;
  logic             out_pol_q;
  logic [TS_W-1:0]  out_ts_q;

  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [RAD_W-1:0]   r_eff;
  logic [CNT_W-1:0]   span;
  logic [COORD_W-1:0] nx, ny;
  logic               nb_ok;
  logic [ADDR_W-1:0]  nb_addr, self_addr, waddr;
  logic [TIME_BITS-1:0] t_now, t_then, t_diff;
  logic [WORD_W-1:0]  wdata, rdata_on, rdata_off, rdata;
  logic               we_on, we_off, hit, clr_last;

  assign w_eff = (32'(frame_width_i) > 32'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : frame_width_i;
  assign h_eff = (32'(frame_height_i) > 32'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                         : frame_height_i;
  assign r_eff = (32'(radius_i) > 32'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius_i);
  assign span  = CNT_W'({r_eff, 1'b0});

  // neighbor coordinates; MSB set means negative
  assign nx = COORD_W'(x_q) + COORD_W'(cx_q) - COORD_W'(r_eff);
  assign ny = COORD_W'(y_q) + COORD_W'(cy_q) - COORD_W'(r_eff);
  assign nb_ok = !nx[COORD_W-1] && (nx < COORD_W'(w_eff)) &&
                 !ny[COORD_W-1] && (ny < COORD_W'(h_eff));

  assign nb_addr   = ADDR_W'(ny) * ADDR_W'(MAX_WIDTH) + ADDR_W'(nx);
  assign self_addr = ADDR_W'(y_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x_q);

  assign t_now  = TIME_BITS'(ts_q);
  assign wdata  = cmd_i.clr ? '0 : {1'b1, t_now};
  assign waddr  = cmd_i.clr ? clr_addr_q : self_addr;
  assign we_on  = cmd_i.clr || (cmd_i.wr && pol_q);
  assign we_off = cmd_i.clr || (cmd_i.wr && !pol_q);

  ebaf_ram #(.WIDTH(WORD_W), .DEPTH(NPIX)) u_on_map (
    .clk_i   (clk_i),
    .we_i    (we_on),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (nb_addr),
    .rdata_o (rdata_on)
  );

  ebaf_ram #(.WIDTH(WORD_W), .DEPTH(NPIX)) u_off_map (
    .clk_i   (clk_i),
    .we_i    (we_off),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (nb_addr),
    .rdata_o (rdata_off)
  );

  // support test on the registered read word
  assign rdata  = pol_q ? rdata_on : rdata_off;
  assign t_then = rdata[TIME_BITS-1:0];
  assign t_diff = t_now - t_then;
  assign hit    = rd_pend_q && rdata[WORD_W-1] &&
                  ((t_now <= t_then) || (CMP_W'(t_diff) <= CMP_W'(time_window_i)));

  assign clr_last = (clr_addr_q == ADDR_W'(NPIX - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q   <= pixel_x_i;
      y_q   <= pixel_y_i;
      pol_q <= polarity_i;
      ts_q  <= timestamp_i;
    end
    if (cmd_i.out_load) begin
      out_x_q   <= x_q;
      out_y_q   <= y_q;
      out_pol_q <= pol_q;
      out_ts_q  <= ts_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q        <= '0;
      cy_q        <= '0;
      rd_pend_q   <= 1'b0;
      pass_q      <= 1'b0;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.rd && nb_ok;
      if (cmd_i.load) begin
        cx_q   <= '0;
        cy_q   <= '0;
        pass_q <= 1'b0;
      end else begin
        if (cmd_i.rd) begin
          if (cx_q == span) begin
            cx_q <= '0;
            cy_q <= cy_q + CNT_W'(1);
          end else begin
            cx_q <= cx_q + CNT_W'(1);
          end
        end
        if (hit) begin
          pass_q <= 1'b1;
        end
      end
      if (cmd_i.clr && !clr_last) begin
        clr_addr_q <= clr_addr_q + ADDR_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.in_frame = ({1'b0, x_q} < w_eff) && ({1'b0, y_q} < h_eff);
  assign sts_o.pos_last = (cx_q == span) && (cy_q == span);
  assign sts_o.pass     = pass_q;
  assign sts_o.clr_last = clr_last;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign out_x_o         = out_x_q;
  assign out_y_o         = out_y_q;
  assign out_polarity_o  = out_pol_q;
  assign out_timestamp_o = out_ts_q;

  a_pass_from_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pass_q) |-> $past(cmd_i.rd, 2))
    else $error("pass flag set without a neighbor read");

  a_out_needs_pass : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pass_q))
    else $error("result issued for an unsupported event");

endmodule
